### hw/rtl/euq_pkg.sv
package euq_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int TRIG_STAGES = 16;
  localparam int CW          = 34;  // CORDIC datapath, Q30 plus headroom
  localparam int TW          = 32;  // cos/sin and pair products, Q30
  localparam int PW          = 64;  // Q60 products
  localparam int SW          = 65;  // Q60 sums
  localparam int QW          = 16;

  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] roll_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
  } euq_in_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
  } euq_out_t;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      default: begin
        if (i <= 30) r = CW'(64'sd1 <<< (30 - i));
        else if (i == 31) r = 34'sd1;
        else r = '0;
      end
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/euler_to_quaternion.sv
// Channel | Dir | Handshake           | Beat payload
// in_     | in  | in_valid / in_stall  | roll, pitch, yaw angle (Q3.12 rad)
// out_    | out | out_valid / out_stall| quaternion w, x, y, z (Q1.15, sat)
//
// One beat accepted per cycle while in_stall is low.
// Depth is set by the unrolled CORDIC: one register stage per iteration.
// Whole pipeline advances together; it freezes only when the output beat is
// held by out_stall. Bubbles travel as cleared valid bits.
// Reset (rst_n low, synchronous) clears all valid bits; data regs keep junk.
module euler_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  euq_pkg::euq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output euq_pkg::euq_out_t out_data
);
  import euq_pkg::*;

  localparam int N = TRIG_STAGES;

  logic en;
  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // ---- stage 0: half angles in Q30 ----
  logic                 v0_r;
  logic signed [CW-1:0] h0_r [0:2];

  function automatic logic signed [CW-1:0] half_q30(input logic signed [ANGLE_BITS-1:0] a);
    logic signed [CW-1:0] e;
    e = CW'(a);
    return e <<< (33 - ANGLE_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (en) v0_r <= in_valid;
    if (en) begin
      h0_r[0] <= half_q30(in_data.roll_angle);
      h0_r[1] <= half_q30(in_data.pitch_angle);
      h0_r[2] <= half_q30(in_data.yaw_angle);
    end
  end

  // ---- stage 1: fold into +-pi/2, CORDIC seed ----
  logic                 cv_r [0:N];
  logic signed [CW-1:0] cx_r [0:N][0:2];
  logic signed [CW-1:0] cy_r [0:N][0:2];
  logic signed [CW-1:0] cz_r [0:N][0:2];
  logic [2:0]           fl_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else if (en) cv_r[0] <= v0_r;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cx_r[0][k] <= GAIN_Q30;
        cy_r[0][k] <= '0;
        if (h0_r[k] > HALF_PI_Q30) begin
          cz_r[0][k] <= h0_r[k] - PI_Q30;
          fl_r[0][k] <= 1'b1;
        end else if (h0_r[k] < -HALF_PI_Q30) begin
          cz_r[0][k] <= h0_r[k] + PI_Q30;
          fl_r[0][k] <= 1'b1;
        end else begin
          cz_r[0][k] <= h0_r[k];
          fl_r[0][k] <= 1'b0;
        end
      end
    end
  end

  // ---- CORDIC iterations, one per stage ----
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [CW-1:0] ATAN_I = atan_q30(i);
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (en) cv_r[i+1] <= cv_r[i];
      if (en) begin
        fl_r[i+1] <= fl_r[i];
        for (int k = 0; k < 3; k++) begin
          if (!cz_r[i][k][CW-1]) begin
            cx_r[i+1][k] <= cx_r[i][k] - (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] + (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] - ATAN_I;
          end else begin
            cx_r[i+1][k] <= cx_r[i][k] + (cy_r[i][k] >>> i);
            cy_r[i+1][k] <= cy_r[i][k] - (cx_r[i][k] >>> i);
            cz_r[i+1][k] <= cz_r[i][k] + ATAN_I;
          end
        end
      end
    end
  end

  // ---- undo fold: cos/sin per angle (0 roll, 1 pitch, 2 yaw) ----
  logic                 tv_r;
  logic signed [TW-1:0] c_r [0:2];
  logic signed [TW-1:0] s_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= 1'b0;
    else if (en) tv_r <= cv_r[N];
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k] <= TW'(fl_r[N][k] ? -cx_r[N][k] : cx_r[N][k]);
        s_r[k] <= TW'(fl_r[N][k] ? -cy_r[N][k] : cy_r[N][k]);
      end
    end
  end

  // ---- roll x pitch pairs, rounded back to Q30 ----
  function automatic logic signed [TW-1:0] mulq30(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + (64'sd1 <<< 29);
    return TW'(p >>> 30);
  endfunction

  logic                 pv_r;
  logic signed [TW-1:0] crcp_r, srsp_r, crsp_r, srcp_r, cy1_r, sy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else if (en) pv_r <= tv_r;
    if (en) begin
      crcp_r <= mulq30(c_r[0], c_r[1]);
      srsp_r <= mulq30(s_r[0], s_r[1]);
      crsp_r <= mulq30(c_r[0], s_r[1]);
      srcp_r <= mulq30(s_r[0], c_r[1]);
      cy1_r  <= c_r[2];
      sy1_r  <= s_r[2];
    end
  end

  // ---- triple products, Q60 ----
  logic                 qv_r;
  logic signed [PW-1:0] t_r [0:7];

  always_ff @(posedge clk) begin
    if (!rst_n) qv_r <= 1'b0;
    else if (en) qv_r <= pv_r;
    if (en) begin
      t_r[0] <= PW'(crcp_r) * PW'(cy1_r);
      t_r[1] <= PW'(srsp_r) * PW'(sy1_r);
      t_r[2] <= PW'(srcp_r) * PW'(cy1_r);
      t_r[3] <= PW'(crsp_r) * PW'(sy1_r);
      t_r[4] <= PW'(crsp_r) * PW'(cy1_r);
      t_r[5] <= PW'(srcp_r) * PW'(sy1_r);
      t_r[6] <= PW'(crcp_r) * PW'(sy1_r);
      t_r[7] <= PW'(srsp_r) * PW'(cy1_r);
    end
  end

  // ---- sums, round to Q15, saturate ----
  function automatic logic signed [QW-1:0] to_q15(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + (65'sd1 <<< 44)) >>> 45;
    if (r > 65'sd32767) return 16'sh7fff;
    if (r < -65'sd32768) return 16'sh8000;
    return QW'(r);
  endfunction

  logic     out_valid_r;
  euq_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= qv_r;
    if (en) begin
      out_data_r.quat_w <= to_q15(SW'(t_r[0]) + SW'(t_r[1]));
      out_data_r.quat_x <= to_q15(SW'(t_r[2]) - SW'(t_r[3]));
      out_data_r.quat_y <= to_q15(SW'(t_r[4]) + SW'(t_r[5]));
      out_data_r.quat_z <= to_q15(SW'(t_r[6]) - SW'(t_r[7]));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- checks ----
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_cordic_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_r[N] && in_stall) |=> cv_r[N])
    else $error("CORDIC beat lost during stall");

endmodule
